FILE: design/los_pkg.sv
package los_pkg;

  localparam int GridW = 64;
  localparam int GridH = 64;
  localparam int CoordW = 6;

  localparam logic OpCell  = 1'b0;
  localparam logic OpPoint = 1'b1;

  typedef struct packed {
    logic              op;
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic              blocked;
    logic              path_last;
  } in_item_t;

  typedef struct packed {
    logic [CoordW-1:0] out_x;
    logic [CoordW-1:0] out_y;
    logic              final_point;
  } out_item_t;

endpackage

FILE: design/los_queue.sv
module los_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  los_pkg::in_item_t wr_item,
  output logic              rd_valid,
  input  logic              rd_ready,
  output los_pkg::in_item_t rd_item
);

  los_pkg::in_item_t mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem_r[wptr_r] <= wr_item;
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wptr_r <= ~wptr_r;
      if (rd_valid && rd_ready) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
    end
  end

endmodule

FILE: design/los_engine.sv
module los_engine #(
  parameter int GRID_W = los_pkg::GridW,
  parameter int GRID_H = los_pkg::GridH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  output logic               item_ready,
  input  los_pkg::in_item_t  item,
  output logic               out_valid,
  input  logic               out_ready,
  output los_pkg::out_item_t out_data
);

  localparam int CW = los_pkg::CoordW;
  localparam int AW = $clog2(GRID_W * GRID_H);
  localparam int SW = CW + 2;  // signed walk width

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_EMIT1 = 3'd3;
  localparam logic [2:0] S_EMIT2 = 3'd4;

  logic grid_r [GRID_W*GRID_H];

  logic [2:0] state_r, state_nxt;
  logic [CW-1:0] ax_r, ay_r, px_r, py_r, cx_r, cy_r;
  logic first_r, last_r, hit_r;
  logic steep_r;
  logic signed [SW-1:0] x_r, x1_r, y_r, err_r, dx_r, dy_r, ystep_r;
  logic rd_en_r, rd_bit_r, rd_in_r;
  logic obuf_v_r;
  los_pkg::out_item_t obuf_r;

  logic obuf_free;
  logic obuf_load;
  assign obuf_free = !obuf_v_r || out_ready;
  assign obuf_load = obuf_free &&
                     ((state_r == S_EMIT1 && hit_r) || (state_r == S_EMIT2));
  assign out_valid = obuf_v_r;
  assign out_data  = obuf_r;
  assign item_ready = (state_r == S_IDLE);

  // setup of the line from anchor to new point
  logic signed [SW-1:0] sx0, sy0, sx1, sy1, adx, ady, tx0, ty0, tx1, ty1;
  logic steep_c;
  always_comb begin
    sx0 = SW'(ax_r);
    sy0 = SW'(ay_r);
    sx1 = SW'(item.cell_x);
    sy1 = SW'(item.cell_y);
    adx = (sx1 > sx0) ? sx1 - sx0 : sx0 - sx1;
    ady = (sy1 > sy0) ? sy1 - sy0 : sy0 - sy1;
    steep_c = ady > adx;
    tx0 = steep_c ? sy0 : sx0;
    ty0 = steep_c ? sx0 : sy0;
    tx1 = steep_c ? sy1 : sx1;
    ty1 = steep_c ? sx1 : sy1;
    if (tx0 > tx1) begin
      {tx0, tx1} = {tx1, tx0};
      {ty0, ty1} = {ty1, ty0};
    end
  end

  // walk cell address
  logic signed [SW-1:0] gx, gy, err_m;
  logic in_grid;
  logic [AW-1:0] raddr;
  always_comb begin
    gx = steep_r ? y_r : x_r;
    gy = steep_r ? x_r : y_r;
    in_grid = (gx >= 0) && (gy >= 0) && (gx < GRID_W) && (gy < GRID_H);
    raddr = AW'(int'(gy) * GRID_W + int'(gx));
    err_m = err_r - (dy_r <<< 1);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (item_valid) begin
        if (item.op == los_pkg::OpCell) state_nxt = S_IDLE;
        else if (first_r) state_nxt = item.path_last ? S_EMIT2 : S_IDLE;
        else state_nxt = S_WALK;
      end
      S_WALK:  if (x_r == x1_r) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_EMIT1;
      S_EMIT1: if (obuf_free) state_nxt = last_r ? S_EMIT2 : S_IDLE;
      S_EMIT2: if (obuf_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_bit_r <= grid_r[raddr];
    if (state_r == S_IDLE && item_valid && item.op == los_pkg::OpCell &&
        item.cell_x < GRID_W && item.cell_y < GRID_H)
      grid_r[AW'(int'(item.cell_y) * GRID_W + int'(item.cell_x))] <= item.blocked;
    if (!rst_n) begin
      state_r <= S_IDLE;
      first_r <= 1'b1;
      ax_r <= '0; ay_r <= '0; px_r <= '0; py_r <= '0;
      obuf_v_r <= 1'b0;
      rd_en_r <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_en_r <= (state_r == S_WALK);
      rd_in_r <= in_grid;
      if (rd_en_r && rd_in_r && rd_bit_r) hit_r <= 1'b1;
      obuf_v_r <= obuf_load || (obuf_v_r && !out_ready);
      case (state_r)
        S_IDLE: if (item_valid && item.op == los_pkg::OpPoint) begin
          cx_r <= item.cell_x; cy_r <= item.cell_y;
          last_r <= item.path_last;
          hit_r <= 1'b0;
          if (first_r) begin
            ax_r <= item.cell_x; ay_r <= item.cell_y;
            px_r <= item.cell_x; py_r <= item.cell_y;
            first_r <= item.path_last;
          end
          steep_r <= steep_c;
          x_r <= tx0; x1_r <= tx1; y_r <= ty0;
          dx_r <= tx1 - tx0;
          dy_r <= (ty1 > ty0) ? ty1 - ty0 : ty0 - ty1;
          err_r <= tx1 - tx0;
          ystep_r <= (ty0 < ty1) ? SW'(1) : -SW'(1);
        end
        S_WALK: begin
          x_r <= x_r + SW'(1);
          if (err_m <= 0) begin
            y_r <= y_r + ystep_r;
            err_r <= err_m + (dx_r <<< 1);
          end else err_r <= err_m;
        end
        S_EMIT1: if (obuf_free) begin
          if (hit_r) begin
            obuf_r <= '{out_x: px_r, out_y: py_r, final_point: 1'b0};
            ax_r <= px_r; ay_r <= py_r;
          end
          px_r <= cx_r; py_r <= cy_r;
          if (last_r) first_r <= 1'b1;
        end
        S_EMIT2: if (obuf_free) begin
          obuf_r <= '{out_x: cx_r, out_y: cy_r, final_point: 1'b1};
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: design/line_of_sight_path_smoothing_top.sv
// Line-of-sight path smoother. Cell writes stream at one per cycle while
// the engine is idle. The first waypoint of a path only sets the anchor (a
// single-point path also emits it as its final point). A later waypoint
// walks the line from the anchor one grid read per cycle through the single
// read port of the occupancy memory: an accept step, a walk over (longer axis
// span + 1) cells, a drain step for the last read, a step that emits the
// previous waypoint if blocked, and a final-point emit on the last waypoint.
// A two-entry queue decouples input acceptance from the walk; one output
// register holds results. Unwritten grid cells read as undefined, so every
// cell a waypoint line crosses must be written first.
module line_of_sight_path_smoothing_top #(
  parameter int GRID_W = los_pkg::GridW,
  parameter int GRID_H = los_pkg::GridH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  los_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output los_pkg::out_item_t out_data
);

  logic q_valid, q_ready;
  los_pkg::in_item_t q_item;

  los_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_item(in_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
  );

  los_engine #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_engine (
    .clk(clk), .rst_n(rst_n),
    .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_q_rst: assert property (@(posedge clk) !rst_n |=> !q_valid && !out_valid)
    else $error("not empty after reset");

endmodule

FILE: verif/los_smoothing_checker.sv
`timescale 1ns / 100ps

module los_smoothing_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  los_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  los_pkg::out_item_t out_data,
  output int                 errors,
  output int                 pending
);

  bit                  grid_blocked [los_pkg::GridW*los_pkg::GridH];
  logic [11:0]         anchor_pt = '0;
  logic [11:0]         prev_pt = '0;
  bit                  new_path = 1'b1;
  los_pkg::out_item_t  kept_points[$];

  function automatic bit is_obstacle(int x, int y);
    if (x < 0 || y < 0 || x >= los_pkg::GridW || y >= los_pkg::GridH) begin
      return 1'b0;
    end
    return grid_blocked[y*los_pkg::GridW + x];
  endfunction

  // Bresenham walk from a to b; true if any visited cell is an obstacle
  function automatic bit sight_blocked(logic [11:0] a, logic [11:0] b);
    int x0, y0, x1, y1, t, dx, dy, err, ystep, y;
    bit steep, hit;
    x0 = int'(a[5:0]);
    y0 = int'(a[11:6]);
    x1 = int'(b[5:0]);
    y1 = int'(b[11:6]);
    steep = ((y1 > y0) ? y1 - y0 : y0 - y1) > ((x1 > x0) ? x1 - x0 : x0 - x1);
    hit = 1'b0;
    if (steep) begin
      t = x0; x0 = y0; y0 = t;
      t = x1; x1 = y1; y1 = t;
    end
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    dx = x1 - x0;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    err = dx;
    ystep = (y0 < y1) ? 1 : -1;
    y = y0;
    for (int x = x0; x <= x1; x++) begin
      if (steep ? is_obstacle(y, x) : is_obstacle(x, y)) begin
        hit = 1'b1;
      end
      err -= 2*dy;
      if (err <= 0) begin
        y += ystep;
        err += 2*dx;
      end
    end
    return hit;
  endfunction

  function automatic los_pkg::out_item_t make_point(logic [11:0] p, logic fin);
    los_pkg::out_item_t r;
    r.out_x = p[5:0];
    r.out_y = p[11:6];
    r.final_point = fin;
    return r;
  endfunction

  task automatic add_kept(los_pkg::out_item_t p);
    kept_points.insert(kept_points.size(), p);
  endtask

  task automatic smooth_item(los_pkg::in_item_t it);
    logic [11:0] pt;
    pt = {it.cell_y, it.cell_x};
    if (it.op == los_pkg::OpCell) begin
      grid_blocked[it.cell_y*los_pkg::GridW + it.cell_x] = it.blocked;
      return;
    end
    if (new_path) begin
      anchor_pt = pt;
      prev_pt = pt;
      new_path = 1'b0;
    end else begin
      if (sight_blocked(anchor_pt, pt)) begin
        add_kept(make_point(prev_pt, 1'b0));
        anchor_pt = prev_pt;
      end
      prev_pt = pt;
    end
    if (it.path_last) begin
      add_kept(make_point(pt, 1'b1));
      new_path = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    los_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (kept_points.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected waypoint x=%0d y=%0d fin=%0b", out_data.out_x,
                     out_data.out_y, out_data.final_point);
          end
        end else begin
          want = kept_points.pop_front();
          if (out_data !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: exp x=%0d y=%0d fin=%0b, got x=%0d y=%0d fin=%0b",
                       want.out_x, want.out_y, want.final_point, out_data.out_x,
                       out_data.out_y, out_data.final_point);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        smooth_item(in_data);
      end
      pending = kept_points.size();
    end
  end

endmodule

FILE: verif/tb_line_of_sight_path_smoothing_top.sv
`timescale 1ns / 100ps

module tb_line_of_sight_path_smoothing_top;

  localparam int IdleLimit = 20000;
  localparam int CW = los_pkg::CoordW;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  los_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready = 1'b0;
  los_pkg::out_item_t out_data;
  int                 errors;
  int                 pending;
  int                 idle_cycles = 0;
  int                 burst_left;
  int                 stall_mode = 0;
  int                 sent;

  line_of_sight_path_smoothing_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  los_smoothing_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: alternate between always-ready stretches and random stalls
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) begin
      stall_mode <= $urandom_range(0, 2);
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // valid stays high across back-to-back items; it drops only for a gap
  task automatic send_item(los_pkg::in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 1) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 80)) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic write_cell(int x, int y, bit blk);
    los_pkg::in_item_t it;
    it.op = los_pkg::OpCell;
    it.cell_x = CW'(x);
    it.cell_y = CW'(y);
    it.blocked = blk;
    it.path_last = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  task automatic send_point(int x, int y, bit last);
    los_pkg::in_item_t it;
    it.op = los_pkg::OpPoint;
    it.cell_x = CW'(x);
    it.cell_y = CW'(y);
    it.blocked = 1'($urandom_range(0, 1));
    it.path_last = last;
    send_item(it);
  endtask

  initial begin
    int len;
    int base;
    int x, y;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    burst_left = 0;
    sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // waypoint lines stay inside these written areas: two corner blocks,
    // row 0, column 63 and the main diagonal
    for (int cy = 0; cy < 20; cy++) begin
      for (int cx = 0; cx < 20; cx++) begin
        write_cell(cx, cy, ($urandom_range(0, 9) == 0));
        write_cell(cx + 44, cy + 44, ($urandom_range(0, 9) == 0));
      end
    end
    for (int k = 20; k < 64; k++) begin
      write_cell(k, 0, ($urandom_range(0, 19) == 0));
    end
    for (int k = 0; k < 44; k++) begin
      write_cell(63, k, ($urandom_range(0, 19) == 0));
    end
    for (int k = 20; k < 44; k++) begin
      write_cell(k, k, (k == 32));
    end

    // directed: single-point path, full-span row, diagonal blocked with last,
    // steep right-to-left column, zero-length line
    write_cell(10, 5, 1'b0);
    send_point(5, 5, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(63, 0, 1'b0);
    send_point(63, 63, 1'b1);
    send_point(63, 63, 1'b0);
    send_point(63, 0, 1'b0);
    send_point(0, 0, 1'b1);
    send_point(44, 44, 1'b0);
    send_point(44, 44, 1'b0);
    send_point(63, 50, 1'b1);

    // drain before continuing
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);

    while (sent < 1500) begin
      if ($urandom_range(0, 3) == 0) begin
        write_cell($urandom_range(0, 63), $urandom_range(0, 63),
                   ($urandom_range(0, 4) == 0));
      end else begin
        len = $urandom_range(1, 8);
        base = ($urandom_range(0, 1) != 0) ? 44 : 0;
        x = base + int'($urandom_range(0, 19));
        y = base + int'($urandom_range(0, 19));
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 4) != 0) begin
            x = base + int'($urandom_range(0, 19));
            y = base + int'($urandom_range(0, 19));
          end
          send_point(x, y, (k == len - 1));
        end
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: line_of_sight_path_smoothing_top.f
design/los_pkg.sv
design/los_queue.sv
design/los_engine.sv
design/line_of_sight_path_smoothing_top.sv
verif/los_smoothing_checker.sv
verif/tb_line_of_sight_path_smoothing_top.sv
